// ===== sv/bios_time_of_day_service_core_assert.svh =====
// Assertion macros for the time-of-day service core.
`ifndef BIOS_TIME_OF_DAY_SERVICE_CORE_ASSERT_SVH
`define BIOS_TIME_OF_DAY_SERVICE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BTOD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define BTOD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BTOD_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define BTOD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/btod_pkg.sv =====
package btod_pkg;

    localparam logic [31:0] DAY_TICKS = 32'h001800B0;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_HOOK  = 3'd1;
    localparam logic [2:0] FUNC_GET   = 3'd2;
    localparam logic [2:0] FUNC_SET   = 3'd3;
    localparam logic [2:0] FUNC_CLOCK = 3'd4;

    typedef struct packed {
        logic [31:0] tick;
        logic [7:0]  roll;
        logic        handled;
        logic        chain;
        logic        clk;
    } meta_t;

    // packed BCD of a value below 60
    function automatic logic [6:0] bcd_of(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] units;
        if (v >= 6'd50) begin
            tens = 3'd5; units = v - 6'd50;
        end else if (v >= 6'd40) begin
            tens = 3'd4; units = v - 6'd40;
        end else if (v >= 6'd30) begin
            tens = 3'd3; units = v - 6'd30;
        end else if (v >= 6'd20) begin
            tens = 3'd2; units = v - 6'd20;
        end else if (v >= 6'd10) begin
            tens = 3'd1; units = v - 6'd10;
        end else begin
            tens = 3'd0; units = v;
        end
        return {tens, units[3:0]};
    endfunction

endpackage

// ===== sv/bios_time_of_day_service_core.sv =====
// Throughput: one item per cycle; the whole 7-register pipeline holds
// while a result waits on m_ready, and the seconds-to-BCD chain sets depth.
// Reset (aresetn low, synchronous): tick count and rollover byte go to zero,
// the pipeline is emptied.
module bios_time_of_day_service_core
    import btod_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [31:0] s_new_ticks,
    input  logic [31:0] s_clock_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_tick_count,
    output logic [7:0]  m_rollover_count,
    output logic [5:0]  m_hours_bcd,
    output logic [6:0]  m_minutes_bcd,
    output logic [6:0]  m_seconds_bcd,
    output logic        m_handled,
    output logic        m_chain_hook
);

    logic        adv;
    logic [6:0]  vld_reg;
    logic [2:0]  func_reg;
    logic [31:0] new_ticks_reg;
    logic [31:0] secs_reg;
    logic [31:0] tick_reg, tick_next;
    logic [7:0]  roll_reg, roll_next;
    meta_t       meta_next;
    meta_t       meta_reg [1:6];
    logic [31:0] tick_inc;
    logic [5:0]  hb;
    logic [6:0]  mb;
    logic [6:0]  sb;

    assign adv     = !vld_reg[6] || m_ready;
    assign s_ready = adv;

    always_comb begin
        tick_next = tick_reg;
        roll_next = roll_reg;
        tick_inc  = tick_reg + 32'd1;
        meta_next.handled = 1'b1;
        meta_next.chain   = 1'b0;
        meta_next.clk     = 1'b0;
        case (func_reg)
            FUNC_TICK: begin
                meta_next.chain = 1'b1;
                if (tick_inc >= DAY_TICKS) begin
                    tick_next = '0;
                    roll_next = roll_reg + 8'd1;
                end else begin
                    tick_next = tick_inc;
                end
            end
            FUNC_HOOK, FUNC_GET: begin
            end
            FUNC_SET: begin
                tick_next = new_ticks_reg;
                roll_next = '0;
            end
            FUNC_CLOCK: begin
                meta_next.clk = 1'b1;
            end
            default: begin
                meta_next.handled = 1'b0;
            end
        endcase
        meta_next.tick = tick_next;
        meta_next.roll = roll_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            tick_reg <= '0;
            roll_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[5:0], s_valid};
            if (vld_reg[0]) begin
                tick_reg <= tick_next;
                roll_reg <= roll_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            func_reg      <= s_func;
            new_ticks_reg <= s_new_ticks;
            secs_reg      <= s_clock_seconds;
            meta_reg[1]   <= meta_next;
            for (int i = 2; i <= 6; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    btod_secs_to_bcd u_conv (
        .aclk        (aclk),
        .en          (adv),
        .secs        (secs_reg),
        .hours_bcd   (hb),
        .minutes_bcd (mb),
        .seconds_bcd (sb)
    );

    assign m_valid          = vld_reg[6];
    assign m_tick_count     = meta_reg[6].tick;
    assign m_rollover_count = meta_reg[6].roll;
    assign m_handled        = meta_reg[6].handled;
    assign m_chain_hook     = meta_reg[6].chain;
    assign m_hours_bcd      = meta_reg[6].clk ? hb : 6'd0;
    assign m_minutes_bcd    = meta_reg[6].clk ? mb : 7'd0;
    assign m_seconds_bcd    = meta_reg[6].clk ? sb : 7'd0;

`include "bios_time_of_day_service_core_assert.svh"

    `BTOD_ASSERT_NEXT(a_tick_below_day, aclk, aresetn, adv && vld_reg[0] && func_reg == FUNC_TICK, tick_reg < DAY_TICKS, "tick left count at or above a day")
    `BTOD_ASSERT_NEXT(a_set_loads, aclk, aresetn, adv && vld_reg[0] && func_reg == FUNC_SET, roll_reg == 8'd0 && tick_reg == $past(new_ticks_reg), "set item did not load count")
    `BTOD_ASSERT_SAME(a_chain_handled, aclk, aresetn, m_valid, !m_chain_hook || m_handled, "chain request on unhandled item")
    `BTOD_ASSERT_SAME(a_bcd_digits, aclk, aresetn, m_valid && meta_reg[6].clk, m_seconds_bcd[3:0] <= 4'd9 && m_seconds_bcd[6:4] <= 3'd5 && m_minutes_bcd[3:0] <= 4'd9 && m_minutes_bcd[6:4] <= 3'd5, "bad BCD digit")

endmodule

// ===== sv/btod_secs_to_bcd.sv =====
module btod_secs_to_bcd
    import btod_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] secs,
    output logic [5:0]  hours_bcd,
    output logic [6:0]  minutes_bcd,
    output logic [6:0]  seconds_bcd
);

    // 86400 = 128 * 675; 3600 = 16 * 225; 60 = 4 * 15
    localparam logic [25:0] RCP_675 = 26'd50903316;   // floor(2^35 / 675)
    localparam logic [12:0] RCP_225 = 13'd4660;       // floor(2^20 / 225)
    localparam logic [10:0] RCP_15  = 11'd1092;       // floor(2^14 / 15)

    logic [15:0] s1_q_reg, s1_q_next;
    logic [31:0] s1_secs_reg;
    logic [16:0] s2_rd_reg, s2_rd_next;
    logic [4:0]  s3_hq_reg, s3_hq_next;
    logic [16:0] s3_rd_reg;
    logic [4:0]  s4_h_reg, s4_h_next;
    logic [11:0] s4_rh_reg, s4_rh_next;
    logic [5:0]  s5_mq_reg, s5_mq_next;
    logic [4:0]  s5_h_reg;
    logic [11:0] s5_rh_reg;
    logic [5:0]  s6_hb_reg, s6_hb_next;
    logic [6:0]  s6_mb_reg, s6_mb_next;
    logic [6:0]  s6_sb_reg, s6_sb_next;

    logic [50:0] p1;
    logic [25:0] r1;
    logic [9:0]  rem675;
    logic [24:0] p3;
    logic [16:0] r3;
    logic [19:0] p5;
    logic [11:0] r5;
    logic [5:0]  min_v;
    logic [5:0]  sec_v;
    logic [6:0]  hb_full;

    always_comb begin
        // quotient estimate of secs[31:7] / 675, low by at most one
        p1        = 51'(secs[31:7]) * 51'(RCP_675);
        s1_q_next = p1[50:35];

        r1     = 26'(s1_secs_reg[31:7]) - 26'(s1_q_reg) * 26'd675;
        rem675 = (r1 >= 26'd675) ? 10'(r1 - 26'd675) : r1[9:0];
        s2_rd_next = {rem675, s1_secs_reg[6:0]};

        p3         = 25'(s2_rd_reg[16:4]) * 25'(RCP_225);
        s3_hq_next = p3[24:20];

        r3 = s3_rd_reg - 17'(s3_hq_reg) * 17'd3600;
        if (r3 >= 17'd3600) begin
            s4_h_next  = s3_hq_reg + 5'd1;
            s4_rh_next = 12'(r3 - 17'd3600);
        end else begin
            s4_h_next  = s3_hq_reg;
            s4_rh_next = r3[11:0];
        end

        p5         = 20'(s4_rh_reg[11:2]) * 20'(RCP_15);
        s5_mq_next = p5[19:14];

        r5 = s5_rh_reg - 12'(s5_mq_reg) * 12'd60;
        if (r5 >= 12'd60) begin
            min_v = s5_mq_reg + 6'd1;
            sec_v = 6'(r5 - 12'd60);
        end else begin
            min_v = s5_mq_reg;
            sec_v = r5[5:0];
        end
        hb_full    = bcd_of({1'b0, s5_h_reg});
        s6_hb_next = hb_full[5:0];
        s6_mb_next = bcd_of(min_v);
        s6_sb_next = bcd_of(sec_v);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_q_reg    <= s1_q_next;
            s1_secs_reg <= secs;
            s2_rd_reg   <= s2_rd_next;
            s3_hq_reg   <= s3_hq_next;
            s3_rd_reg   <= s2_rd_reg;
            s4_h_reg    <= s4_h_next;
            s4_rh_reg   <= s4_rh_next;
            s5_mq_reg   <= s5_mq_next;
            s5_h_reg    <= s4_h_reg;
            s5_rh_reg   <= s4_rh_reg;
            s6_hb_reg   <= s6_hb_next;
            s6_mb_reg   <= s6_mb_next;
            s6_sb_reg   <= s6_sb_next;
        end
    end

    assign hours_bcd   = s6_hb_reg;
    assign minutes_bcd = s6_mb_reg;
    assign seconds_bcd = s6_sb_reg;

endmodule

// ===== dv/tb.sv =====
module tb;
    import btod_pkg::*;

    localparam logic [2:0] FUNC_OTHER = 3'd5;
    localparam logic [2:0] FUNC_LAST  = 3'd7;
    localparam int         ITEM_TARGET = 1625;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         SETTLE_CYCLES = 20;

    typedef struct packed {
        logic        drain_first;
        logic [2:0]  func;
        logic [31:0] new_ticks;
        logic [31:0] clock_seconds;
    } tod_req_t;

    typedef struct packed {
        logic [31:0] tick;
        logic [7:0]  roll;
        logic [5:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic        handled;
        logic        chain;
    } tod_result_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [31:0] s_new_ticks = '0;
    logic [31:0] s_clock_seconds = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_tick_count;
    logic [7:0]  m_rollover_count;
    logic [5:0]  m_hours_bcd;
    logic [6:0]  m_minutes_bcd;
    logic [6:0]  m_seconds_bcd;
    logic        m_handled;
    logic        m_chain_hook;

    tod_req_t    pending_reqs[$];
    tod_result_t tod_expected[$];
    tod_req_t    cur_req;
    tod_result_t want;

    logic [31:0] model_ticks = '0;
    logic [7:0]  model_rollover = '0;

    int          n_queued = 0;
    int          items_taken = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        launch;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic        rx_ready_nxt;

    bios_time_of_day_service_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_new_ticks      (s_new_ticks),
        .s_clock_seconds  (s_clock_seconds),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tick_count     (m_tick_count),
        .m_rollover_count (m_rollover_count),
        .m_hours_bcd      (m_hours_bcd),
        .m_minutes_bcd    (m_minutes_bcd),
        .m_seconds_bcd    (m_seconds_bcd),
        .m_handled        (m_handled),
        .m_chain_hook     (m_chain_hook)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] to_packed_bcd(input logic [31:0] v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // advances the tick/rollover state by one request and returns its result
    function automatic tod_result_t service_request(input tod_req_t r);
        tod_result_t res;
        logic [31:0] next_ticks;
        logic [7:0]  hb, mb, sb;
        res = '0;
        res.handled = 1'b1;
        case (r.func)
            FUNC_TICK: begin
                next_ticks = model_ticks + 32'd1;
                if (next_ticks >= DAY_TICKS) begin
                    next_ticks = '0;
                    model_rollover = model_rollover + 8'd1;
                end
                model_ticks = next_ticks;
                res.chain = 1'b1;
            end
            FUNC_HOOK, FUNC_GET: ;
            FUNC_SET: begin
                model_ticks = r.new_ticks;
                model_rollover = '0;
            end
            FUNC_CLOCK: begin
                hb = to_packed_bcd((r.clock_seconds / 3600) % 24);
                mb = to_packed_bcd((r.clock_seconds / 60) % 60);
                sb = to_packed_bcd(r.clock_seconds % 60);
                res.hours = hb[5:0];
                res.minutes = mb[6:0];
                res.seconds = sb[6:0];
            end
            default: res.handled = 1'b0;
        endcase
        res.tick = model_ticks;
        res.roll = model_rollover;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic queue_req(input logic [2:0] func, input logic [31:0] nt,
                             input logic [31:0] cs, input logic drain);
        tod_req_t r;
        r.drain_first = drain;
        r.func = func;
        r.new_ticks = nt;
        r.clock_seconds = cs;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    function automatic logic [31:0] rand_secs();
        return ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 200000);
    endfunction

    function automatic logic [2:0] rand_func();
        return 3'($urandom_range(0, FUNC_LAST));
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            launch = 1'b0;
            if (s_valid && s_ready) begin
                tod_expected.push_back(service_request(cur_req));
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].drain_first && tod_expected.size() > 0)) begin
                    cur_req = pending_reqs.pop_front();
                    launch = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                s_valid <= launch;
            end
            if (launch) begin
                s_func <= cur_req.func;
                s_new_ticks <= cur_req.new_ticks;
                s_clock_seconds <= cur_req.clock_seconds;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tod_expected.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = tod_expected.pop_front();
                if (m_tick_count !== want.tick)
                    report_mismatch($sformatf("tick_count got %h exp %h",
                                              m_tick_count, want.tick));
                if (m_rollover_count !== want.roll)
                    report_mismatch($sformatf("rollover_count got %h exp %h",
                                              m_rollover_count, want.roll));
                if (m_hours_bcd !== want.hours)
                    report_mismatch($sformatf("hours_bcd got %h exp %h",
                                              m_hours_bcd, want.hours));
                if (m_minutes_bcd !== want.minutes)
                    report_mismatch($sformatf("minutes_bcd got %h exp %h",
                                              m_minutes_bcd, want.minutes));
                if (m_seconds_bcd !== want.seconds)
                    report_mismatch($sformatf("seconds_bcd got %h exp %h",
                                              m_seconds_bcd, want.seconds));
                if (m_handled !== want.handled)
                    report_mismatch($sformatf("handled got %b exp %b",
                                              m_handled, want.handled));
                if (m_chain_hook !== want.chain)
                    report_mismatch($sformatf("chain_hook got %b exp %b",
                                              m_chain_hook, want.chain));
            end
        end
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   rx_ready_nxt = 1'b1;
            RX_COIN:   rx_ready_nxt = 1'($urandom_range(0, 1));
            RX_SPARSE: rx_ready_nxt = ($urandom_range(0, 3) == 0);
            default:   rx_ready_nxt = (rx_left % 8) < 3;
        endcase
        m_ready <= rx_ready_nxt;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] load;
        // directed: reset state, every request, day wrap, all-ones wrap, BCD extremes
        queue_req(FUNC_GET,      32'hFFFFFFFF, 32'h0,        1'b0);
        queue_req(FUNC_TICK,     32'h0,        32'hFFFFFFFF, 1'b0);
        queue_req(FUNC_HOOK,     32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        queue_req(FUNC_OTHER,    32'h12345678, 32'd3599,     1'b0);
        queue_req(FUNC_OTHER + 3'd1, 32'h0,    32'd0,        1'b0);
        queue_req(FUNC_LAST,     32'hFFFFFFFF, 32'd86399,    1'b0);
        queue_req(FUNC_SET,      32'hFFFFFFFF, 32'd0,        1'b0);
        queue_req(FUNC_TICK,     32'h0,        32'd0,        1'b0);
        queue_req(FUNC_GET,      32'h0,        32'd0,        1'b0);
        queue_req(FUNC_SET,      DAY_TICKS - 32'd2, 32'd0,   1'b0);
        queue_req(FUNC_TICK,     32'h0,        32'd0,        1'b0);
        queue_req(FUNC_TICK,     32'h0,        32'd0,        1'b0);
        queue_req(FUNC_GET,      32'h0,        32'd0,        1'b0);
        queue_req(FUNC_TICK,     32'h0,        32'd0,        1'b0);
        queue_req(FUNC_SET,      DAY_TICKS + 32'd5, 32'd0,   1'b0);
        queue_req(FUNC_TICK,     32'h0,        32'd0,        1'b0);
        queue_req(FUNC_SET,      32'h0,        32'd0,        1'b0);
        queue_req(FUNC_CLOCK,    32'h0,        32'd0,        1'b0);
        queue_req(FUNC_CLOCK,    32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
        queue_req(FUNC_CLOCK,    32'h0,        32'd86399,    1'b0);
        queue_req(FUNC_CLOCK,    32'h0,        32'd86400,    1'b0);
        queue_req(FUNC_CLOCK,    32'h0,        32'd3599,     1'b0);
        queue_req(FUNC_CLOCK,    32'h0,        32'd45296,    1'b0);
        // random: mostly a load (often near a wrap point) followed by tick-heavy runs
        while (n_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 4) begin
                queue_req(rand_func(), $urandom, rand_secs(),
                          n_queued == 23 || n_queued == 800);
            end else begin
                case ($urandom_range(0, 3))
                    0:       load = DAY_TICKS - $urandom_range(1, 6);
                    1:       load = DAY_TICKS + $urandom_range(0, 1000000);
                    2:       load = 32'hFFFFFFFF - $urandom_range(0, 4);
                    default: load = $urandom;
                endcase
                queue_req(FUNC_SET, load, rand_secs(),
                          n_queued == 23 || n_queued == 800);
                repeat ($urandom_range(2, 12))
                    queue_req(($urandom_range(0, 9) < 7) ? FUNC_TICK : rand_func(),
                              $urandom, rand_secs(), 1'b0);
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_taken < n_queued) @(posedge aclk);
        while (tod_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
